/* sv/vcr_pkg.sv */
// ----------------------------------------------------------------------------
// vcr_pkg: shared types and constants for the velocity curve ramp
// Sizes, register indexes, curve codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vcr_pkg;

  localparam int MAX_NOTES = 64;
  localparam int IDX_W     = $clog2(MAX_NOTES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int TICK_W    = 32;
  localparam int ID_W      = 16;
  localparam int VEL_W     = 8;
  localparam int FRAC_W    = 16;              // Q1.16 position
  localparam int POS_W     = FRAC_W + 1;      // 0..65536
  localparam int DIV_W     = IDX_W + FRAC_W;  // rank << 16 plus half divisor
  localparam int STEP_W    = 5;
  localparam int ROOT_IN_W = 2 * POS_W;       // radicand t << 16, padded even
  localparam int ROOT_RM_W = POS_W + 3;

  typedef enum logic [1:0] {
    CFG_START_VEL = 2'd0,
    CFG_END_VEL   = 2'd1,
    CFG_CURVE     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_SQUARE = 2'd1,
    CURVE_ROOT   = 2'd2,
    CURVE_SMOOTH = 2'd3
  } curve_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_PICK,
    ST_DIV,
    ST_SHAPE,
    ST_SM_LO,
    ST_SM_HI,
    ST_ROOT,
    ST_SET_S,
    ST_BLEND,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;        // note transfer on the input side
    logic scan_init;
    logic scan_step;
    logic pick;        // claim minimum, start division
    logic div_step;
    logic shape_init;  // square product, root setup
    logic sm_lo;
    logic sm_hi;
    logic root_step;
    logic s_set;
    logic blend;
    logic emit;
    logic rank_inc;
    logic run_clr;
  } cmd_t;

  typedef struct packed {
    logic   scan_done;
    logic   div_last;
    logic   root_last;
    logic   lone;
    logic   last_rank;
    logic   out_free;
    curve_e mode;
  } stat_t;

endpackage

`default_nettype wire

/* sv/vcr_ram.sv */
// ----------------------------------------------------------------------------
// vcr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* sv/vcr_ctrl.sv */
// ----------------------------------------------------------------------------
// vcr_ctrl: sequencer for the velocity curve ramp
// Loads notes; per rank: scan, divide, shape, blend, emit (lone: scan, emit).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vcr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  input  wire vcr_pkg::stat_t stat_i,
  output vcr_pkg::cmd_t      cmd_o
);

  vcr_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = in_valid_i && (state_q == vcr_pkg::ST_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vcr_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vcr_pkg::ST_LOAD: begin
        if (accept && in_last_i) state_d = vcr_pkg::ST_SCAN_INIT;
      end
      vcr_pkg::ST_SCAN_INIT: state_d = vcr_pkg::ST_SCAN;
      vcr_pkg::ST_SCAN: begin
        if (stat_i.scan_done) state_d = vcr_pkg::ST_PICK;
      end
      vcr_pkg::ST_PICK: begin
        state_d = stat_i.lone ? vcr_pkg::ST_EMIT : vcr_pkg::ST_DIV;
      end
      vcr_pkg::ST_DIV: begin
        if (stat_i.div_last) state_d = vcr_pkg::ST_SHAPE;
      end
      vcr_pkg::ST_SHAPE: begin
        unique case (stat_i.mode)
          vcr_pkg::CURVE_ROOT:   state_d = vcr_pkg::ST_ROOT;
          vcr_pkg::CURVE_SMOOTH: state_d = vcr_pkg::ST_SM_LO;
          default:               state_d = vcr_pkg::ST_SET_S;
        endcase
      end
      vcr_pkg::ST_SM_LO: state_d = vcr_pkg::ST_SM_HI;
      vcr_pkg::ST_SM_HI: state_d = vcr_pkg::ST_SET_S;
      vcr_pkg::ST_ROOT: begin
        if (stat_i.root_last) state_d = vcr_pkg::ST_SET_S;
      end
      vcr_pkg::ST_SET_S: state_d = vcr_pkg::ST_BLEND;
      vcr_pkg::ST_BLEND: state_d = vcr_pkg::ST_EMIT;
      vcr_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = stat_i.last_rank ? vcr_pkg::ST_LOAD : vcr_pkg::ST_SCAN_INIT;
        end
      end
      default: state_d = vcr_pkg::ST_LOAD;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      vcr_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = accept;
      end
      vcr_pkg::ST_SCAN_INIT: cmd_o.scan_init = 1'b1;
      vcr_pkg::ST_SCAN:      cmd_o.scan_step = 1'b1;
      vcr_pkg::ST_PICK:      cmd_o.pick = 1'b1;
      vcr_pkg::ST_DIV:       cmd_o.div_step = 1'b1;
      vcr_pkg::ST_SHAPE:     cmd_o.shape_init = 1'b1;
      vcr_pkg::ST_SM_LO:     cmd_o.sm_lo = 1'b1;
      vcr_pkg::ST_SM_HI:     cmd_o.sm_hi = 1'b1;
      vcr_pkg::ST_ROOT:      cmd_o.root_step = 1'b1;
      vcr_pkg::ST_SET_S:     cmd_o.s_set = 1'b1;
      vcr_pkg::ST_BLEND:     cmd_o.blend = 1'b1;
      vcr_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.rank_inc = !stat_i.last_rank;
          cmd_o.run_clr  = stat_i.last_rank;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/vcr_dp.sv */
// ----------------------------------------------------------------------------
// vcr_dp: datapath for the velocity curve ramp
// Note stores, minimum scan, restoring divider and square root, curve
// multiplies, blend and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vcr_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire vcr_pkg::cmd_t                 cmd_i,
  output vcr_pkg::stat_t                     stat_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [vcr_pkg::VEL_W-1:0]     cfg_data_i,
  input  wire logic [vcr_pkg::ID_W-1:0]      note_id_i,
  input  wire logic [vcr_pkg::TICK_W-1:0]    note_start_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [vcr_pkg::ID_W-1:0]           result_id_o,
  output logic [vcr_pkg::VEL_W-1:0]          note_vel_o,
  output logic                               last_result_o,
  output logic                               overflowed_o
);

  localparam int IW = vcr_pkg::IDX_W;
  localparam int CW = vcr_pkg::CNT_W;
  localparam int PW = vcr_pkg::POS_W;
  localparam int DW = vcr_pkg::DIV_W;
  localparam int RW = vcr_pkg::ROOT_RM_W;
  localparam int XW = vcr_pkg::ROOT_IN_W;

  // configuration registers
  logic [vcr_pkg::VEL_W-1:0] start_vel_q, end_vel_q;
  vcr_pkg::curve_e           mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_vel_q <= '0;
      end_vel_q   <= 8'd127;
      mode_q      <= vcr_pkg::CURVE_LINEAR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vcr_pkg::CFG_START_VEL: start_vel_q <= cfg_data_i;
        vcr_pkg::CFG_END_VEL:   end_vel_q   <= cfg_data_i;
        vcr_pkg::CFG_CURVE:     mode_q      <= vcr_pkg::curve_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // run control: fill count, overflow, claimed entries, rank
  logic [CW-1:0]                cnt_q;
  logic                         ovf_q;
  logic [vcr_pkg::MAX_NOTES-1:0] used_q;
  logic [IW-1:0]                rank_q;
  logic                         full;
  logic [IW-1:0]                den;

  assign full = (cnt_q == CW'(vcr_pkg::MAX_NOTES));
  assign den  = IW'(cnt_q - CW'(1));

  // scan pipeline state
  logic [CW-1:0]             a_q;
  logic                      p_vld_q;
  logic [IW-1:0]             p_idx_q;
  logic                      best_vld_q;
  logic [vcr_pkg::TICK_W-1:0] best_key_q;
  logic [IW-1:0]             best_idx_q;
  logic [vcr_pkg::TICK_W-1:0] key_rdata;
  logic [vcr_pkg::ID_W-1:0]  id_rdata;
  logic                      better;

  vcr_ram #(.WIDTH(vcr_pkg::TICK_W), .DEPTH(vcr_pkg::MAX_NOTES)) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && !full),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (note_start_i),
    .raddr_i (a_q[IW-1:0]),
    .rdata_o (key_rdata)
  );

  vcr_ram #(.WIDTH(vcr_pkg::ID_W), .DEPTH(vcr_pkg::MAX_NOTES)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && !full),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (note_id_i),
    .raddr_i (best_idx_q),
    .rdata_o (id_rdata)
  );

  // strict less-than keeps the earliest arrival on equal ticks
  assign better = p_vld_q && !used_q[p_idx_q] && (!best_vld_q || key_rdata < best_key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      used_q     <= '0;
      rank_q     <= '0;
      a_q        <= '0;
      p_vld_q    <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (full) ovf_q <= 1'b1;
        else      cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.scan_init) begin
        a_q        <= '0;
        p_vld_q    <= 1'b0;
        best_vld_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        p_vld_q <= (a_q != cnt_q);
        if (a_q != cnt_q) a_q <= a_q + CW'(1);
        if (better) best_vld_q <= 1'b1;
      end
      if (cmd_i.pick) used_q[best_idx_q] <= 1'b1;
      if (cmd_i.rank_inc) rank_q <= rank_q + IW'(1);
      if (cmd_i.run_clr) begin
        cnt_q  <= '0;
        ovf_q  <= 1'b0;
        used_q <= '0;
        rank_q <= '0;
      end
    end
  end

  // scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      p_idx_q <= a_q[IW-1:0];
      if (better) begin
        best_key_q <= key_rdata;
        best_idx_q <= p_idx_q;
      end
    end
  end

  // restoring divider and square root share the step counter
  logic [vcr_pkg::STEP_W-1:0] k_q;
  logic [DW-1:0]              dq_q;
  logic [IW-1:0]              drem_q;
  logic [IW:0]                drem2;
  logic                       dge;
  logic [XW-1:0]              rx_q;
  logic [RW-1:0]              rrem_q;
  logic [PW-1:0]              root_q;
  logic [RW-1:0]              rrem2, trial;
  logic                       rge;
  logic [PW-1:0]              t, root_s;

  assign t     = dq_q[PW-1:0];
  assign drem2 = {drem_q, dq_q[DW-1]};
  assign dge   = (drem2 >= {1'b0, den});
  assign rrem2 = {rrem_q[RW-3:0], rx_q[XW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign rge   = (rrem2 >= trial);
  assign root_s = (rrem_q > RW'(root_q)) ? root_q + PW'(1) : root_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      k_q    <= '0;
      drem_q <= '0;
      dq_q   <= DW'({rank_q, {vcr_pkg::FRAC_W{1'b0}}}) + DW'(den >> 1);
    end
    if (cmd_i.div_step) begin
      k_q    <= k_q + vcr_pkg::STEP_W'(1);
      drem_q <= dge ? IW'(drem2 - {1'b0, den}) : drem2[IW-1:0];
      dq_q   <= {dq_q[DW-2:0], dge};
    end
    if (cmd_i.shape_init) begin
      k_q    <= '0;
      rrem_q <= '0;
      root_q <= '0;
      rx_q   <= XW'({t, {vcr_pkg::FRAC_W{1'b0}}});
    end
    if (cmd_i.root_step) begin
      k_q    <= k_q + vcr_pkg::STEP_W'(1);
      rrem_q <= rge ? rrem2 - trial : rrem2;
      root_q <= {root_q[PW-2:0], rge};
      rx_q   <= {rx_q[XW-3:0], 2'b00};
    end
  end

  // curve multiplies
  logic [2*PW-1:0] p_q;
  logic [PW:0]     q3;
  logic [51:0]     acc_q, acc_rnd;
  logic [2*PW:0]   sm_part;
  logic [2*PW:0]   sq_rnd;
  logic [PW-1:0]   sq_s, sm_s, s_q;

  assign q3      = (PW+1)'(3 * (1 << vcr_pkg::FRAC_W)) - {t, 1'b0};
  assign sm_part = (cmd_i.sm_lo ? p_q[PW-1:0] : p_q[2*PW-1:PW]) * q3;
  assign sq_rnd  = (2*PW+1)'(p_q) + (2*PW+1)'(1 << (vcr_pkg::FRAC_W - 1));
  assign sq_s    = sq_rnd[vcr_pkg::FRAC_W +: PW];
  assign acc_rnd = acc_q + 52'h0_0000_8000_0000;
  assign sm_s    = acc_rnd[32 +: PW];

  // blend
  logic signed [8:0]  diff;
  logic signed [PW:0] s_sx;
  logic signed [26:0] num_q;
  logic signed [26:0] base;
  logic [10:0]        vr;
  logic [vcr_pkg::VEL_W-1:0] vel;

  assign diff = $signed({1'b0, end_vel_q}) - $signed({1'b0, start_vel_q});
  assign s_sx = $signed({1'b0, s_q});
  assign base = $signed(27'({start_vel_q, {vcr_pkg::FRAC_W{1'b0}}}));
  assign vr   = 11'((num_q + 27'sd32768) >>> vcr_pkg::FRAC_W);

  always_comb begin
    if (cnt_q == CW'(1))         vel = start_vel_q;
    else if (num_q < 0)          vel = '0;
    else if (vr > 11'd127)       vel = 8'd127;
    else                         vel = vr[vcr_pkg::VEL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shape_init) p_q <= t * t;
    if (cmd_i.sm_lo)      acc_q <= 52'(sm_part);
    if (cmd_i.sm_hi)      acc_q <= acc_q + (52'(sm_part) << PW);
    if (cmd_i.s_set) begin
      unique case (mode_q)
        vcr_pkg::CURVE_LINEAR: s_q <= t;
        vcr_pkg::CURVE_SQUARE: s_q <= sq_s;
        vcr_pkg::CURVE_ROOT:   s_q <= root_s;
        vcr_pkg::CURVE_SMOOTH: s_q <= sm_s;
        default:               s_q <= t;
      endcase
    end
    if (cmd_i.blend) num_q <= base + 27'(diff * s_sx);
  end

  // output register
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_id_o    <= id_rdata;
      note_vel_o     <= vel;
      last_result_o  <= (rank_q == den);
      overflowed_o   <= ovf_q;
    end
  end

  assign out_valid_o = out_vld_q;

  // status back to the controller
  assign stat_o.scan_done = (a_q == cnt_q) && !p_vld_q;
  assign stat_o.div_last  = (k_q == vcr_pkg::STEP_W'(DW - 1));
  assign stat_o.root_last = (k_q == vcr_pkg::STEP_W'(PW - 1));
  assign stat_o.lone      = (cnt_q == CW'(1));
  assign stat_o.last_rank = (rank_q == den);
  assign stat_o.out_free  = !out_vld_q || out_ready_i;
  assign stat_o.mode      = mode_q;

endmodule

`default_nettype wire

/* sv/velocity_curve_ramp_top.sv */
// ----------------------------------------------------------------------------
// velocity_curve_ramp_top: sorted velocity ramp over a set of notes
// Notes stream in on s_axis, one per cycle, until a transfer with tlast.
// The stored notes are then ordered by start tick (equal ticks keep arrival
// order) and one result per note leaves on m_axis in that order, carrying
// a velocity from start_velocity to end_velocity shaped by curve_mode.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
// the block is idle. Up to 64 notes are held; extra notes are dropped and
// every result of that run shows tuser = 1.
// Each result then runs a minimum scan over the tick memory, a 22-step
// serial divide for the position, the curve shaping (with a 17-step serial
// square root for the root curve) and the blend; a lone note goes straight
// from the scan to the output.
// The result sits in an output register, so work on the next result goes
// on while m_axis is stalled; the sequencer waits only to load it again.
// Reset empties the note set and restores start 0, end 127, linear curve.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module velocity_curve_ramp_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // [15:0] note_id, [47:16] note_start
  input  wire logic        s_axis_tlast,   // last_note
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [15:0] result_id, [23:16] note_vel
  output logic             m_axis_tlast,   // last_result
  output logic             m_axis_tuser,   // [0] overflowed
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i
);

  vcr_pkg::cmd_t  cmd;
  vcr_pkg::stat_t stat;

  vcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vcr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .note_id_i      (s_axis_tdata[15:0]),
    .note_start_i   (s_axis_tdata[47:16]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .result_id_o    (m_axis_tdata[15:0]),
    .note_vel_o     (m_axis_tdata[23:16]),
    .last_result_o  (m_axis_tlast),
    .overflowed_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* dv/velocity_curve_ramp_top_tb.sv */
// ----------------------------------------------------------------------------
// velocity_curve_ramp_top_tb: self-checking bench for the velocity ramp
// Streams note sets into s_axis and predicts each result: a stable sort by
// start tick, then a Q1.16 position shaped by the selected curve and blended
// from start to end velocity. Every m_axis transfer is checked field by
// field in order. Covers lone notes, ties, all curves, register extremes,
// store overflow, long output stalls and random idle bursts on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module velocity_curve_ramp_top_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [15:0] id;
    logic [7:0]  vel;
    logic        last;
    logic        ovf;
  } ramp_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [15:0] note_id, [47:16] note_start
  logic        s_axis_tlast = 1'b0; // last_note
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [15:0] result_id, [23:16] note_vel
  logic        m_axis_tlast;        // last_result
  logic        m_axis_tuser;        // [0] overflowed
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;

  velocity_curve_ramp_top DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]      vel_from = 8'd0;
  logic [7:0]      vel_to = 8'd127;
  vcr_pkg::curve_e curve = vcr_pkg::CURVE_LINEAR;
  logic [15:0]     held_ids[$];
  logic [31:0]     held_ticks[$];
  logic            dropped = 1'b0;
  ramp_result_t    pending_results[$];

  int  errors = 0;
  int  notes_sent = 0;
  int  results_seen = 0;
  int  cycles = 0;
  bit  idling = 1'b1;
  bit  hold_out = 1'b0;
  bit  curve_used[4];

  // --------------------------------------------------------------------------
  // curve shaping and velocity blend
  // --------------------------------------------------------------------------
  function automatic longint unsigned round_sqrt(longint unsigned x);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd1 << 21;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    if (x - lo * lo > lo) lo++;
    return lo;
  endfunction

  function automatic logic [7:0] ramp_velocity(int rank, int n);
    longint unsigned t, s, den;
    longint num;
    longint unsigned v;
    if (n == 1) return vel_from;
    den = n - 1;
    t = ((longint'(rank) << 16) + den / 2) / den;
    case (curve)
      vcr_pkg::CURVE_SQUARE: s = (t * t + 32768) >> 16;
      vcr_pkg::CURVE_ROOT:   s = round_sqrt(t << 16);
      vcr_pkg::CURVE_SMOOTH: s = (t * t * (3 * 65536 - 2 * t) + 64'h8000_0000) >> 32;
      default:               s = t;
    endcase
    num = (longint'(vel_from) << 16) + (longint'(vel_to) - longint'(vel_from)) * longint'(s);
    if (num < 0) num = 0;
    v = (unsigned'(num) + 32768) >> 16;
    if (v > 127) v = 127;
    return v[7:0];
  endfunction

  // accepted note: store it, and on the final one queue the sorted ramp
  task automatic absorb_note(logic [15:0] id, logic [31:0] tick, logic fin);
    int order[$];
    int j, n;
    ramp_result_t r;
    if (held_ids.size() < vcr_pkg::MAX_NOTES) begin
      held_ids.push_back(id);
      held_ticks.push_back(tick);
    end else begin
      dropped = 1'b1;
    end
    if (!fin) return;
    n = held_ids.size();
    // stable insertion by tick
    for (int i = 0; i < n; i++) begin
      j = order.size();
      while (j > 0 && held_ticks[order[j-1]] > held_ticks[i]) j--;
      order.insert(j, i);
    end
    for (int i = 0; i < n; i++) begin
      r.id   = held_ids[order[i]];
      r.vel  = ramp_velocity(i, n);
      r.last = (i == n - 1);
      r.ovf  = dropped;
      pending_results.push_back(r);
    end
    curve_used[curve] = 1'b1;
    held_ids.delete();
    held_ticks.delete();
    dropped = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  task automatic send_note(logic [15:0] id, logic [31:0] tick, logic fin);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tick, id};
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_note(id, tick, fin);
    notes_sent++;
  endtask

  task automatic send_set(int n, int tick_span);
    for (int i = 0; i < n; i++)
      send_note(16'($urandom()), (tick_span == 0) ? $urandom() : $urandom_range(0, tick_span),
                i == n - 1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(vcr_pkg::cfg_idx_e idx, logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      vcr_pkg::CFG_START_VEL: vel_from = val;
      vcr_pkg::CFG_END_VEL:   vel_to = val;
      default:                curve = vcr_pkg::curve_e'(val[1:0]);
    endcase
  endtask

  task automatic set_ramp(logic [7:0] from, logic [7:0] to, vcr_pkg::curve_e c);
    write_reg(vcr_pkg::CFG_START_VEL, from);
    write_reg(vcr_pkg::CFG_END_VEL, to);
    write_reg(vcr_pkg::CFG_CURVE, {6'd0, c});
  endtask

  // --------------------------------------------------------------------------
  // receiver side: random stall bursts, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        m_axis_tready <= 1'b0;
        repeat (1500) @(posedge clk_i);
        hold_out = 1'b0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result id=%0h", m_axis_tdata[15:0]);
        errors++;
      end else begin
        ramp_result_t r;
        r = pending_results.pop_front();
        if (m_axis_tdata[15:0] !== r.id) begin
          $error("result_id exp %0h got %0h", r.id, m_axis_tdata[15:0]); errors++;
        end
        if (m_axis_tdata[23:16] !== r.vel) begin
          $error("note_vel exp %0d got %0d", r.vel, m_axis_tdata[23:16]); errors++;
        end
        if (m_axis_tlast !== r.last) begin
          $error("last_result exp %0b got %0b", r.last, m_axis_tlast); errors++;
        end
        if (m_axis_tuser !== r.ovf) begin
          $error("overflowed exp %0b got %0b", r.ovf, m_axis_tuser); errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    // lone note with reset registers, then raw start above 127
    send_note(16'h0000, 32'h0000_0000, 1'b1);
    wait_idle();
    set_ramp(8'd200, 8'd0, vcr_pkg::CURVE_LINEAR);
    send_note(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    wait_idle();
    // extremes of ticks, ties keeping arrival order, descending ramp
    send_note(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_note(16'h0001, 32'd5, 1'b0);
    send_note(16'h0002, 32'd5, 1'b0);
    send_note(16'h0000, 32'h0000_0000, 1'b0);
    send_note(16'h0003, 32'd5, 1'b1);
    wait_idle();
    // each curve over the full range
    for (int c = 0; c < 4; c++) begin
      set_ramp(8'd0, 8'd255, vcr_pkg::curve_e'(c));
      send_set(4, 0);
      wait_idle();
    end
  endtask

  task automatic test_overflow();
    set_ramp(8'd10, 8'd120, vcr_pkg::CURVE_SMOOTH);
    send_set(vcr_pkg::MAX_NOTES, 0);
    wait_idle();
    send_set(vcr_pkg::MAX_NOTES + 2, 0);
    wait_idle();
  endtask

  task automatic test_output_stall();
    set_ramp(8'd127, 8'd1, vcr_pkg::CURVE_ROOT);
    hold_out = 1'b1;
    send_set(6, 3);
    send_set(5, 0);  // offered while the output is held
    wait_idle();
  endtask

  task automatic test_random();
    int n;
    while (notes_sent < 230) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0: set_ramp(8'd0, 8'd255, vcr_pkg::curve_e'($urandom_range(0, 3)));
          1: set_ramp(8'd255, 8'd0, vcr_pkg::curve_e'($urandom_range(0, 3)));
          default: set_ramp(8'($urandom()), 8'($urandom()),
                            vcr_pkg::curve_e'($urandom_range(0, 3)));
        endcase
      end
      if (notes_sent > 190) idling = 1'b0;
      n = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 10);
      send_set(n, ($urandom_range(0, 2) == 0) ? 7 : 0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_output_stall();
    test_random();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d notes, checked %0d results over %0d cycles.",
             notes_sent, results_seen, cycles);
    $display("Curves exercised: linear %0b square %0b root %0b smoothstep %0b.",
             curve_used[0], curve_used[1], curve_used[2], curve_used[3]);
    if (errors == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
